FILE: rtl/ps2dec_pkg.sv
// Shared types, constants and lookup functions for the set-1 scan code decoder.
// No dependencies; imported by ps2dec_core and ps2_scancode_to_ascii_decoder.
package ps2dec_pkg;

  // Number of terminals that can be targeted by a switch request.
  localparam int TerminalCount = 3;

  localparam logic [6:0] CodeTop    = 7'h3D;
  localparam logic [6:0] TableLen   = 7'h3B;
  localparam logic [6:0] CodeEsc    = 7'h01;
  localparam logic [6:0] CodeTab    = 7'h0F;
  localparam logic [6:0] CodeKpStar = 7'h37;
  localparam logic [6:0] CodeLCtrl  = 7'h1D;
  localparam logic [6:0] CodeLShift = 7'h2A;
  localparam logic [6:0] CodeRShift = 7'h36;
  localparam logic [6:0] CodeLAlt   = 7'h38;
  localparam logic [6:0] CodeCaps   = 7'h3A;
  localparam logic [6:0] CodeLKey   = 7'h26;
  localparam logic [6:0] CodeF1     = 7'h3B;
  localparam logic [6:0] CodeDigit1 = 7'h02;

  typedef enum logic [1:0] {
    ACT_NONE   = 2'd0,
    ACT_CHAR   = 2'd1,
    ACT_CLEAR  = 2'd2,
    ACT_SWITCH = 2'd3
  } action_t;

  typedef struct packed {
    logic [1:0] terminal_index;
    logic [6:0] char_code;
    action_t    action;
  } result_t;

  // Letter keys are the three alphabetic rows of the main block.
  function automatic logic is_letter(input logic [6:0] key);
    is_letter = (key >= 7'h10 && key <= 7'h19) || (key >= 7'h1E && key <= 7'h26) ||
                (key >= 7'h2C && key <= 7'h32);
  endfunction

  // ASCII lookup; returns the shifted character when sel is set.
  function automatic logic [6:0] key_char(input logic [6:0] key, input logic sel);
    logic [13:0] pair;  // {shifted, unshifted}
    unique case (key)
      7'h02:   pair = {7'h21, 7'h31};
      7'h03:   pair = {7'h40, 7'h32};
      7'h04:   pair = {7'h23, 7'h33};
      7'h05:   pair = {7'h24, 7'h34};
      7'h06:   pair = {7'h25, 7'h35};
      7'h07:   pair = {7'h5E, 7'h36};
      7'h08:   pair = {7'h26, 7'h37};
      7'h09:   pair = {7'h2A, 7'h38};
      7'h0A:   pair = {7'h28, 7'h39};
      7'h0B:   pair = {7'h29, 7'h30};
      7'h0C:   pair = {7'h5F, 7'h2D};
      7'h0D:   pair = {7'h2B, 7'h3D};
      7'h0E:   pair = {7'h08, 7'h08};
      7'h10:   pair = {7'h51, 7'h71};
      7'h11:   pair = {7'h57, 7'h77};
      7'h12:   pair = {7'h45, 7'h65};
      7'h13:   pair = {7'h52, 7'h72};
      7'h14:   pair = {7'h54, 7'h74};
      7'h15:   pair = {7'h59, 7'h79};
      7'h16:   pair = {7'h55, 7'h75};
      7'h17:   pair = {7'h49, 7'h69};
      7'h18:   pair = {7'h4F, 7'h6F};
      7'h19:   pair = {7'h50, 7'h70};
      7'h1A:   pair = {7'h7B, 7'h5B};
      7'h1B:   pair = {7'h7D, 7'h5D};
      7'h1C:   pair = {7'h0A, 7'h0A};
      7'h1E:   pair = {7'h41, 7'h61};
      7'h1F:   pair = {7'h53, 7'h73};
      7'h20:   pair = {7'h44, 7'h64};
      7'h21:   pair = {7'h46, 7'h66};
      7'h22:   pair = {7'h47, 7'h67};
      7'h23:   pair = {7'h48, 7'h68};
      7'h24:   pair = {7'h4A, 7'h6A};
      7'h25:   pair = {7'h4B, 7'h6B};
      7'h26:   pair = {7'h4C, 7'h6C};
      7'h27:   pair = {7'h3A, 7'h3B};
      7'h28:   pair = {7'h22, 7'h27};
      7'h29:   pair = {7'h7E, 7'h60};
      7'h2B:   pair = {7'h7C, 7'h5C};
      7'h2C:   pair = {7'h5A, 7'h7A};
      7'h2D:   pair = {7'h58, 7'h78};
      7'h2E:   pair = {7'h43, 7'h63};
      7'h2F:   pair = {7'h56, 7'h76};
      7'h30:   pair = {7'h42, 7'h62};
      7'h31:   pair = {7'h4E, 7'h6E};
      7'h32:   pair = {7'h4D, 7'h6D};
      7'h33:   pair = {7'h3C, 7'h2C};
      7'h34:   pair = {7'h3E, 7'h2E};
      7'h35:   pair = {7'h3F, 7'h2F};
      7'h39:   pair = {7'h20, 7'h20};
      default: pair = 14'h0;
    endcase
    key_char = sel ? pair[13:7] : pair[6:0];
  endfunction

endpackage

FILE: rtl/ps2dec_core.sv
// Modifier state, test mode register and the per-beat decode of one scan code.
// Depends on ps2dec_pkg.
module ps2dec_core
  import ps2dec_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_wr_en,
  input  logic       cfg_wr_data,
  input  logic       step,       // the code below is consumed this cycle
  input  logic [7:0] code,
  output result_t    result
);

  logic test_mode_r;
  logic shift_r, shift_nxt;
  logic ctrl_r, ctrl_nxt;
  logic alt_r, alt_nxt;
  logic caps_r, caps_nxt;

  logic [6:0] key;
  logic       rel;
  logic [6:0] term;
  logic       want_switch;
  logic       sel;

  assign key = code[6:0];
  assign rel = code[7];

  always_comb begin
    shift_nxt   = shift_r;
    ctrl_nxt    = ctrl_r;
    alt_nxt     = alt_r;
    caps_nxt    = caps_r;
    result      = '{terminal_index: 2'd0, char_code: 7'd0, action: ACT_NONE};
    term        = 7'd0;
    want_switch = 1'b0;
    sel         = shift_r ^ (is_letter(key) & caps_r);

    if (key > CodeTop || key == CodeEsc || key == CodeTab || key == CodeKpStar) begin
      result.action = ACT_NONE;
    end else if (key == CodeLCtrl) begin
      ctrl_nxt = !rel;
    end else if (key == CodeLShift || key == CodeRShift) begin
      shift_nxt = !rel;
    end else if (key == CodeLAlt) begin
      alt_nxt = !rel;
    end else if (key == CodeCaps) begin
      if (!rel) begin
        caps_nxt = !caps_r;
      end
    end else if (rel) begin
      result.action = ACT_NONE;
    end else if (ctrl_r && key == CodeLKey) begin
      result.action = ACT_CLEAR;
    end else if (alt_r && key >= CodeF1 && key <= CodeF1 + 7'd2) begin
      want_switch = 1'b1;
      term        = key - CodeF1;
    end else if (alt_r && test_mode_r && key >= CodeDigit1 && key <= CodeDigit1 + 7'd2) begin
      want_switch = 1'b1;
      term        = key - CodeDigit1;
    end else if (key == 7'd0 || key >= TableLen) begin
      result.action = ACT_NONE;
    end else begin
      result.action    = ACT_CHAR;
      result.char_code = key_char(key, sel);
    end

    // A switch to a terminal that does not exist is dropped silently.
    if (want_switch && (32'(term) < TerminalCount)) begin
      result.action         = ACT_SWITCH;
      result.terminal_index = term[1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      test_mode_r <= 1'b1;
      shift_r     <= 1'b0;
      ctrl_r      <= 1'b0;
      alt_r       <= 1'b0;
      caps_r      <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        test_mode_r <= cfg_wr_data;
      end
      if (step) begin
        shift_r <= shift_nxt;
        ctrl_r  <= ctrl_nxt;
        alt_r   <= alt_nxt;
        caps_r  <= caps_nxt;
      end
    end
  end

endmodule

FILE: rtl/ps2_scancode_to_ascii_decoder.sv
// Top level of the set-1 scan code to ASCII decoder: input register, result register.
// Depends on ps2dec_pkg and ps2dec_core.
//
//  Channel  | Direction | Payload
//  ---------+-----------+------------------------------------------------------
//  in_      | slave     | tdata[7:0] scan_code
//  out_     | master    | tdata[1:0] action, [8:2] char_code, [10:9] terminal_index
//  cfg_     | write     | wr_data: test_mode_enable
//
// One beat is accepted per cycle while in_tready is high. A result passes through
// the input register and then the result register before it appears on out_.
// The decode of one code is a single pass through the modifier logic and the
// ASCII table between those two registers. When out_tready is low the result
// register holds and the input register fills; in_tready drops only when both
// are full. Reset (rst_n low, synchronous) empties both registers, clears the
// modifier state and sets test mode on.
module ps2_scancode_to_ascii_decoder
  import ps2dec_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,    // test_mode_enable
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,       // [7:0] scan_code
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata       // [1:0] action, [8:2] char_code, [10:9] terminal_index
);

  // Input register stage.
  logic       in_vld_r;
  logic [7:0] in_code_r;

  // Result register stage.
  logic       out_vld_r;
  result_t    out_res_r;
  result_t    dec_res;

  logic       adv;      // input register moves into the result register
  logic       in_take;

  // The result register can load when it is empty or is being drained this cycle.
  assign adv     = in_vld_r && (!out_vld_r || out_tready);
  assign in_tready = !in_vld_r || adv;
  assign in_take = in_tvalid && in_tready;

  // Modifier state advances exactly when a beat passes into the result register,
  // so state updates happen in arrival order.
  ps2dec_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .step        (adv),
    .code        (in_code_r),
    .result      (dec_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (in_take) begin
        in_vld_r <= 1'b1;
      end else if (adv) begin
        in_vld_r <= 1'b0;
      end
      if (adv) begin
        out_vld_r <= 1'b1;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (in_take) begin
      in_code_r <= in_tdata;
    end
    if (adv) begin
      out_res_r <= dec_res;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {5'd0, out_res_r.terminal_index, out_res_r.char_code,
                       out_res_r.action};

  // A character code is only ever carried by a character result.
  a_char_only_with_char: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_res_r.action != ACT_CHAR) |-> (out_res_r.char_code == 7'd0))
    else $error("char_code set on a non-character result");

  // Terminal index is zero unless a switch, and a switch never targets a missing terminal.
  a_term_only_with_switch: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> ((out_res_r.action == ACT_SWITCH) ?
                   (32'(out_res_r.terminal_index) < TerminalCount) :
                   (out_res_r.terminal_index == 2'd0)))
    else $error("terminal_index inconsistent with action");

  // A stalled result is never overwritten by the decode stage.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && !out_tready) |-> !adv)
    else $error("result register overwritten while stalled");

  // A beat waiting in the input register holds off the input only when the output stalls.
  a_ready_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (in_vld_r && out_vld_r && !out_tready))
    else $error("input stalled without back-pressure");

endmodule
